>>> rtl/core/twr_pkg.sv
// ----------------------------------------------------------------------------
// twr_pkg
// shared codes, widths and types of the two-way ranging engine
// ----------------------------------------------------------------------------
package twr_pkg;

  localparam int TsW  = 40;
  localparam int IvW  = 32;
  localparam int DenW = 34;
  localparam int DvdW = 72;
  localparam int CntW = 7;

  // action codes
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_POLL    = 3'd1;
  localparam logic [2:0] ACT_ANSWER  = 3'd2;
  localparam logic [2:0] ACT_FINAL   = 3'd3;
  localparam logic [2:0] ACT_REPORT  = 3'd4;
  localparam logic [2:0] ACT_RESTART = 3'd5;

  // event kinds
  localparam logic [2:0] EV_RX        = 3'd0;
  localparam logic [2:0] EV_TX        = 3'd1;
  localparam logic [2:0] EV_RX_TMO    = 3'd2;
  localparam logic [2:0] EV_TIMER_TMO = 3'd3;
  localparam logic [2:0] EV_RX_FAIL   = 3'd4;

  // message types
  localparam logic [2:0] MSG_POLL   = 3'd0;
  localparam logic [2:0] MSG_ANSWER = 3'd1;
  localparam logic [2:0] MSG_FINAL  = 3'd2;
  localparam logic [2:0] MSG_REPORT = 3'd3;

  // register indexes
  localparam logic REG_ANT_DELAY = 1'b0;
  localparam logic REG_INTERVAL  = 1'b1;

  localparam logic [15:0] ANT_DELAY_RST = 16'd32951;
  localparam logic [31:0] INTERVAL_RST  = 32'd4000;

  // distance = q8 * DIST_NUM / (DIST_DEN_LOW * 2^DIST_SHIFT)
  localparam logic [27:0] DIST_NUM     = 28'd149896229;
  localparam logic [9:0]  DIST_DEN_LOW = 10'd975;
  localparam int          DIST_SHIFT   = 23;

  typedef struct packed {
    logic [TsW-1:0] flight;
    logic [31:0]    dist_mm;
    logic           zero_div;
  } range_res_t;

endpackage

>>> rtl/core/twr_range.sv
// ----------------------------------------------------------------------------
// twr_range
// serial range unit: shift-add multiplier and restoring divider, one bit a cycle
// ----------------------------------------------------------------------------
module twr_range (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [31:0]           r1,
  input  logic [31:0]           p1,
  input  logic [31:0]           r2,
  input  logic [31:0]           p2,
  output logic                  done,
  output twr_pkg::range_res_t   res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULA = 4'd1;
  localparam logic [3:0] S_MULB = 4'd2;
  localparam logic [3:0] S_MAG  = 4'd3;
  localparam logic [3:0] S_DIV1 = 4'd4;
  localparam logic [3:0] S_SAT  = 4'd5;
  localparam logic [3:0] S_MULK = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam int DvdW = twr_pkg::DvdW;
  localparam int DenW = twr_pkg::DenW;

  logic [3:0]                 state_r;
  logic [twr_pkg::CntW-1:0]   cnt_r;
  logic [DvdW-1:0]            mcand_r;
  logic [39:0]                mplier_r;
  logic [DvdW-1:0]            acc_r;
  logic [DvdW-1:0]            dvd_r;
  logic [DenW-1:0]            rem_r;
  logic [DenW-1:0]            dsr_r;
  logic [31:0]                p1_r, p2_r;
  logic [63:0]                a_r;
  logic                       neg_r;
  logic [39:0]                q8_r;
  twr_pkg::range_res_t        res_r;

  logic [DenW-1:0]  den;
  logic [DvdW-1:0]  acc_sum;
  logic [DenW:0]    trial;
  logic             ge;
  logic [DenW-1:0]  rem_nxt;
  logic [DvdW-1:0]  dvd_nxt;
  logic             last;
  logic [63:0]      mag;
  logic             sat;
  logic [39:0]      q8;
  logic [44:0]      dq;
  logic [31:0]      dsat;

  assign den = {2'b0, r1} + {2'b0, r2} + {2'b0, p1} + {2'b0, p2};
  assign acc_sum = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign trial = {rem_r, dvd_r[DvdW-1]};
  assign ge = trial >= {1'b0, dsr_r};
  assign rem_nxt = ge ? DenW'(trial - {1'b0, dsr_r}) : trial[DenW-1:0];
  assign dvd_nxt = {dvd_r[DvdW-2:0], ge};
  assign last = cnt_r == twr_pkg::CntW'(1);
  assign mag = (a_r < acc_r[63:0]) ? acc_r[63:0] - a_r : a_r - acc_r[63:0];
  assign sat = dvd_r[DvdW-1:39] != '0;
  assign q8 = sat ? (neg_r ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF) : dvd_r[39:0];
  assign dq = dvd_nxt[44:0];
  // clamp the distance magnitude to the signed range
  always_comb begin
    if (neg_r) begin
      dsat = (dq > 45'h0_8000_0000) ? 32'h8000_0000 : dq[31:0];
    end else begin
      dsat = (dq > 45'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : dq[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            p1_r  <= p1;
            p2_r  <= p2;
            dsr_r <= den;
            if (den == '0) begin
              res_r   <= '{flight: '0, dist_mm: '0, zero_div: 1'b1};
              state_r <= S_FIN;
            end else begin
              mcand_r  <= {40'b0, r1};
              mplier_r <= {8'b0, r2};
              acc_r    <= '0;
              cnt_r    <= twr_pkg::CntW'(32);
              state_r  <= S_MULA;
            end
          end
        end
        S_MULA, S_MULB, S_MULK: begin
          acc_r    <= acc_sum;
          mcand_r  <= {mcand_r[DvdW-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[39:1]};
          cnt_r    <= cnt_r - twr_pkg::CntW'(1);
          if (last) begin
            if (state_r == S_MULA) begin
              a_r      <= acc_sum[63:0];
              mcand_r  <= {40'b0, p1_r};
              mplier_r <= {8'b0, p2_r};
              acc_r    <= '0;
              cnt_r    <= twr_pkg::CntW'(32);
              state_r  <= S_MULB;
            end else if (state_r == S_MULB) begin
              state_r <= S_MAG;
            end else begin
              dvd_r   <= {27'b0, acc_sum[67:twr_pkg::DIST_SHIFT]};
              dsr_r   <= {24'b0, twr_pkg::DIST_DEN_LOW};
              rem_r   <= '0;
              cnt_r   <= twr_pkg::CntW'(DvdW);
              state_r <= S_DIV2;
            end
          end
        end
        S_MAG: begin
          // acc holds p1*p2 here
          neg_r   <= a_r < acc_r[63:0];
          dvd_r   <= {mag, 8'b0};
          rem_r   <= '0;
          cnt_r   <= twr_pkg::CntW'(DvdW);
          state_r <= S_DIV1;
        end
        S_DIV1, S_DIV2: begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_nxt;
          cnt_r <= cnt_r - twr_pkg::CntW'(1);
          if (last) begin
            if (state_r == S_DIV1) begin
              state_r <= S_SAT;
            end else begin
              res_r.dist_mm  <= neg_r ? 32'(0 - dsat) : dsat;
              res_r.flight   <= neg_r ? 40'(0 - q8_r) : q8_r;
              res_r.zero_div <= 1'b0;
              state_r        <= S_FIN;
            end
          end
        end
        S_SAT: begin
          q8_r     <= q8;
          mcand_r  <= {32'b0, q8};
          mplier_r <= {12'b0, twr_pkg::DIST_NUM};
          acc_r    <= '0;
          cnt_r    <= twr_pkg::CntW'(28);
          state_r  <= S_MULK;
        end
        S_FIN: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign done = state_r == S_FIN;
  assign res  = res_r;

endmodule

>>> rtl/core/twr_ranging_engine.sv
// ----------------------------------------------------------------------------
// twr_ranging_engine
// double-sided two-way ranging engine for a uwb radio
// ----------------------------------------------------------------------------
// One radio event is taken per item and gives one result item. Every event
// but a received report is answered in the result register in the next
// cycle. A received report starts the serial range unit, which works one bit
// a cycle: a start step, two multiplies, a magnitude step, a divide, a
// saturation step, a multiply by the distance constant, a divide by its odd
// part and a finishing step; with a zero divisor it goes from the start
// straight to the finishing step. The input stalls while the range unit is
// busy or a result waits on a stalled output.
// ----------------------------------------------------------------------------
module twr_ranging_engine (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // radio events
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_event_kind,
  input  logic [39:0] in_radio_time,
  input  logic        in_rx_empty,
  input  logic [2:0]  in_rx_type,
  input  logic [7:0]  in_rx_seq,
  input  logic [39:0] in_rx_peer_poll_rx,
  input  logic [39:0] in_rx_peer_answer_tx,
  input  logic [39:0] in_rx_peer_final_rx,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [7:0]  out_tx_seq,
  output logic [39:0] out_tx_poll_rx,
  output logic [39:0] out_tx_answer_tx,
  output logic [39:0] out_tx_final_rx,
  output logic        out_range_valid,
  output logic signed [39:0] out_flight_ticks_q8,
  output logic signed [31:0] out_distance_mm,
  output logic        out_zero_divisor,
  output logic [31:0] out_next_timeout
);

  // configuration registers
  logic [15:0] ant_delay_r;
  logic [31:0] interval_r;

  // ranging state
  logic [39:0] poll_tx_r, poll_rx_r, ans_tx_r, ans_rx_r, fin_tx_r, fin_rx_r;
  logic [2:0]  last_tx_r;
  logic [7:0]  own_seq_r;
  logic [31:0] held_tmo_r;

  // control
  logic        busy_r;
  logic        start_r;
  logic        out_valid_r;

  // result register
  logic [2:0]  act_r;
  logic [7:0]  seq_r;
  logic [39:0] rep_poll_r, rep_ans_r, rep_fin_r;
  logic        rng_r;
  logic [39:0] flight_r;
  logic [31:0] dist_r;
  logic        zd_r;
  logic [31:0] tmo_r;

  logic                accept;
  logic                out_take;
  logic [39:0]         half;
  logic [39:0]         arrive;
  logic [39:0]         depart;
  logic                rng_done;
  twr_pkg::range_res_t rng_res;

  assign out_take = out_valid_r & ~out_stall;
  assign in_stall = busy_r | (out_valid_r & out_stall);
  assign accept   = in_valid & ~in_stall;

  // half the antenna delay comes off receive stamps and goes on send stamps
  assign half   = {25'b0, ant_delay_r[15:1]};
  assign arrive = in_radio_time - half;
  assign depart = in_radio_time + half;

  twr_range u_range (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .r1    (ans_rx_r[31:0] - poll_tx_r[31:0]),
    .p1    (ans_tx_r[31:0] - poll_rx_r[31:0]),
    .r2    (fin_rx_r[31:0] - ans_tx_r[31:0]),
    .p2    (fin_tx_r[31:0] - ans_rx_r[31:0]),
    .done  (rng_done),
    .res   (rng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ant_delay_r <= twr_pkg::ANT_DELAY_RST;
      interval_r  <= twr_pkg::INTERVAL_RST;
      poll_tx_r   <= '0;
      poll_rx_r   <= '0;
      ans_tx_r    <= '0;
      ans_rx_r    <= '0;
      fin_tx_r    <= '0;
      fin_rx_r    <= '0;
      last_tx_r   <= twr_pkg::ACT_NONE;
      own_seq_r   <= '0;
      held_tmo_r  <= '0;
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_take) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          twr_pkg::REG_ANT_DELAY: ant_delay_r <= cfg_wdata[15:0];
          twr_pkg::REG_INTERVAL:  interval_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // range finished: the result register is free by now
      if (rng_done) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        flight_r    <= rng_res.flight;
        dist_r      <= rng_res.dist_mm;
        zd_r        <= rng_res.zero_div;
      end

      if (accept) begin
        // defaults for a plain result
        act_r       <= twr_pkg::ACT_NONE;
        seq_r       <= '0;
        rep_poll_r  <= '0;
        rep_ans_r   <= '0;
        rep_fin_r   <= '0;
        rng_r       <= 1'b0;
        flight_r    <= '0;
        dist_r      <= '0;
        zd_r        <= 1'b0;
        tmo_r       <= held_tmo_r;
        out_valid_r <= 1'b1;
        case (in_event_kind)
          twr_pkg::EV_RX: begin
            if (in_rx_empty) begin
              held_tmo_r <= '0;
              tmo_r      <= '0;
            end else begin
              case (in_rx_type)
                twr_pkg::MSG_POLL: begin
                  poll_rx_r <= arrive;
                  last_tx_r <= twr_pkg::ACT_ANSWER;
                  act_r     <= twr_pkg::ACT_ANSWER;
                  seq_r     <= in_rx_seq;
                end
                twr_pkg::MSG_ANSWER: begin
                  ans_rx_r  <= arrive;
                  last_tx_r <= twr_pkg::ACT_FINAL;
                  act_r     <= twr_pkg::ACT_FINAL;
                  seq_r     <= in_rx_seq;
                end
                twr_pkg::MSG_FINAL: begin
                  fin_rx_r   <= arrive;
                  last_tx_r  <= twr_pkg::ACT_REPORT;
                  act_r      <= twr_pkg::ACT_REPORT;
                  seq_r      <= in_rx_seq;
                  rep_poll_r <= poll_rx_r;
                  rep_ans_r  <= ans_tx_r;
                  rep_fin_r  <= arrive;
                end
                twr_pkg::MSG_REPORT: begin
                  // peer stamps replace ours, then the range unit runs
                  poll_rx_r   <= in_rx_peer_poll_rx;
                  ans_tx_r    <= in_rx_peer_answer_tx;
                  fin_rx_r    <= in_rx_peer_final_rx;
                  act_r       <= twr_pkg::ACT_RESTART;
                  rng_r       <= 1'b1;
                  held_tmo_r  <= interval_r;
                  tmo_r       <= interval_r;
                  busy_r      <= 1'b1;
                  start_r     <= 1'b1;
                  out_valid_r <= 1'b0;
                end
                default: ;
              endcase
            end
          end
          twr_pkg::EV_TX: begin
            case (last_tx_r)
              twr_pkg::ACT_POLL:   poll_tx_r <= depart;
              twr_pkg::ACT_ANSWER: ans_tx_r  <= depart;
              twr_pkg::ACT_FINAL:  fin_tx_r  <= depart;
              default: ;
            endcase
            held_tmo_r <= interval_r;
            tmo_r      <= interval_r;
          end
          twr_pkg::EV_RX_TMO: begin
            act_r <= twr_pkg::ACT_RESTART;
          end
          twr_pkg::EV_TIMER_TMO: begin
            poll_tx_r  <= '0;
            poll_rx_r  <= '0;
            ans_tx_r   <= '0;
            ans_rx_r   <= '0;
            fin_tx_r   <= '0;
            fin_rx_r   <= '0;
            own_seq_r  <= 8'd1;
            last_tx_r  <= twr_pkg::ACT_POLL;
            act_r      <= twr_pkg::ACT_POLL;
            seq_r      <= 8'd1;
            held_tmo_r <= '0;
            tmo_r      <= '0;
          end
          twr_pkg::EV_RX_FAIL: begin
            tmo_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_action          = act_r;
  // a new poll carries our own sequence number
  assign out_tx_seq          = (act_r == twr_pkg::ACT_POLL) ? own_seq_r : seq_r;
  assign out_tx_poll_rx      = rep_poll_r;
  assign out_tx_answer_tx    = rep_ans_r;
  assign out_tx_final_rx     = rep_fin_r;
  assign out_range_valid     = rng_r;
  assign out_flight_ticks_q8 = flight_r;
  assign out_distance_mm     = dist_r;
  assign out_zero_divisor    = zd_r;
  assign out_next_timeout    = tmo_r;

endmodule
